/* src/tlv_value_record_parser_core_macros.svh */
// ----------------------------------------------------------------------------
// tlv_value_record_parser_core_macros.svh
// Assertion macros for the value record parser. Empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef TLV_VALUE_RECORD_PARSER_CORE_MACROS_SVH
`define TLV_VALUE_RECORD_PARSER_CORE_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define TLVP_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("tlvp assertion failed");
// condition must never be true out of reset
`define TLVP_ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("tlvp forbidden condition seen");
`else
`define TLVP_ASSERT(lbl, clk, rst_n, prop)
`define TLVP_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

/* src/tlvp_pkg.sv */
// ----------------------------------------------------------------------------
// tlvp_pkg
// Shared types and codes of the value record parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tlvp_pkg;

	// result kinds
	localparam logic [2:0] KIND_NUMERIC   = 3'd0;
	localparam logic [2:0] KIND_CHAR      = 3'd1;
	localparam logic [2:0] KIND_STR_END   = 3'd2;
	localparam logic [2:0] KIND_INVALID   = 3'd3;
	localparam logic [2:0] KIND_NOT_FOUND = 3'd4;

	// configuration register indexes
	localparam logic CFG_MATCH_ENABLE = 1'b0;
	localparam logic CFG_MATCH_ID     = 1'b1;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  out_id;
		logic [2:0]  out_kind;
		logic [31:0] out_value;
		logic        out_last;
	} out_item_t;

	typedef struct packed {
		logic       match_enable;
		logic [7:0] match_id;
	} cfg_t;

	// results caused by one byte: cnt of them, r0 first
	typedef struct packed {
		logic [1:0] cnt;
		out_item_t  r0;
		out_item_t  r1;
	} result_pair_t;

	typedef struct packed {
		logic [1:0] cnt;
		logic       can_load;
	} buf_status_t;

endpackage

/* src/tlv_value_record_parser_core.sv */
// ----------------------------------------------------------------------------
// tlv_value_record_parser_core
// Byte-stream parser for id/type value records with an optional id filter.
//
//   channel | dir | handshake             | payload
//   in      | in  | in_valid / in_ready   | in_data  (byte, last flag)
//   out     | out | out_valid / out_ready | out_data (id, kind, value, last)
//   cfg     | in  | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One byte per cycle while the result pair can load: input register, parse logic,
// result register pair. A byte that causes two results holds the next byte
// until the single result port has drained the pair.
// Reset clears parse state, configuration and valid flags at once; no clearing pass.
// Output stalls back up through the result pair to in_ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "tlv_value_record_parser_core_macros.svh"

module tlv_value_record_parser_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  tlvp_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output tlvp_pkg::out_item_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_index,
	input  logic [7:0]          cfg_data
);

	tlvp_pkg::in_item_t     item_s1;
	logic                   valid_s1;
	tlvp_pkg::cfg_t         cfg_q;
	tlvp_pkg::result_pair_t pair;
	tlvp_pkg::buf_status_t  bstat;
	logic                   advance;

	assign cfg_ready = 1'b1;
	assign advance = valid_s1 && bstat.can_load;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				tlvp_pkg::CFG_MATCH_ENABLE: cfg_q.match_enable <= cfg_data[0];
				tlvp_pkg::CFG_MATCH_ID:     cfg_q.match_id <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) item_s1 <= in_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	tlvp_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.cfg     (cfg_q),
		.pair    (pair)
	);

	tlvp_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance),
		.pair      (pair),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_data  (out_data),
		.status    (bstat)
	);

	// first of two held results never closes the byte's transaction group
	`TLVP_ASSERT(a_pair_head_not_last, clk, arst_n, (bstat.cnt == 2'd2) |-> !out_data.out_last)
	// input only stalls behind a pending result
	`TLVP_ASSERT(a_stall_needs_result, clk, arst_n, (!in_ready) |-> (valid_s1 && out_valid))
	// not found is always the final result of its byte
	`TLVP_ASSERT_NEVER(a_nf_last, clk, arst_n, out_valid && !out_data.out_last && out_data.out_kind == tlvp_pkg::KIND_NOT_FOUND)

endmodule

/* src/tlvp_parse.sv */
// ----------------------------------------------------------------------------
// tlvp_parse
// Record parse state and the per-byte next-state / result logic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tlvp_parse (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  advance,
	input  tlvp_pkg::in_item_t    item,
	input  tlvp_pkg::cfg_t        cfg,
	output tlvp_pkg::result_pair_t pair
);

	typedef enum logic [2:0] {
		PH_ID, PH_TYPE, PH_PAYLOAD, PH_STRING, PH_PAD, PH_SKIP
	} phase_t;

	localparam logic [1:0] RT_NUM4  = 2'd0;
	localparam logic [1:0] RT_NUM10 = 2'd1;
	localparam logic [1:0] RT_STR   = 2'd2;

	phase_t      phase_q, phase_n;
	logic [7:0]  rid_q, rid_n;
	logic [1:0]  rtype_q, rtype_n;
	logic [3:0]  pcnt_q, pcnt_n;
	logic [31:0] vs_q, vs_n;
	logic        found_q, found_n;

	logic        rep, rep_end;
	logic        m_v, l_v, nf_v;
	logic [2:0]  m_kind;
	logic [31:0] m_val;
	logic [7:0]  b;

	always_comb begin
		b = item.in_byte;
		phase_n = phase_q;
		rid_n = rid_q;
		rtype_n = rtype_q;
		pcnt_n = pcnt_q;
		vs_n = vs_q;
		found_n = found_q;
		m_v = 1'b0;
		m_kind = tlvp_pkg::KIND_NUMERIC;
		m_val = '0;
		l_v = 1'b0;
		nf_v = 1'b0;
		rep = !cfg.match_enable || (rid_q == cfg.match_id);

		case (phase_q)
			PH_ID: begin
				rid_n = b;
				pcnt_n = '0;
				vs_n = '0;
				phase_n = PH_TYPE;
			end
			PH_TYPE: begin
				if (b == 8'd1 || b == 8'd3 || b == 8'd4) begin
					rtype_n = (b == 8'd1) ? RT_NUM4 : (b == 8'd3) ? RT_NUM10 : RT_STR;
					pcnt_n = '0;
					phase_n = PH_PAYLOAD;
				end else begin
					m_v = rep;
					m_kind = tlvp_pkg::KIND_INVALID;
					if (rep && cfg.match_enable) found_n = 1'b1;
					phase_n = PH_SKIP;
				end
			end
			PH_PAYLOAD: begin
				if (rtype_q == RT_NUM4) begin
					vs_n = {vs_q[23:0], b};
					if (pcnt_q >= 4'd3) begin
						m_v = rep;
						m_val = vs_n;
						if (rep && cfg.match_enable) begin
							found_n = 1'b1;
							phase_n = PH_SKIP;
						end else begin
							phase_n = PH_PAD;
						end
					end else begin
						pcnt_n = pcnt_q + 4'd1;
					end
				end else if (rtype_q == RT_NUM10) begin
					// five skipped bytes, then the value in bytes 5-8
					if (pcnt_q >= 4'd5) vs_n = {vs_q[23:0], b};
					if (pcnt_q >= 4'd8) begin
						m_v = rep;
						m_val = vs_n;
						if (rep && cfg.match_enable) begin
							found_n = 1'b1;
							phase_n = PH_SKIP;
						end else begin
							phase_n = PH_PAD;
						end
					end else begin
						pcnt_n = pcnt_q + 4'd1;
					end
				end else begin
					if (pcnt_q >= 4'd4) phase_n = PH_STRING;
					else pcnt_n = pcnt_q + 4'd1;
				end
			end
			PH_STRING: begin
				if (b == 8'd0) begin
					m_v = rep;
					m_kind = tlvp_pkg::KIND_STR_END;
					if (rep && cfg.match_enable) begin
						found_n = 1'b1;
						phase_n = PH_SKIP;
					end else begin
						phase_n = PH_PAD;
					end
				end else begin
					m_v = rep;
					m_kind = tlvp_pkg::KIND_CHAR;
					m_val = {24'd0, b};
				end
			end
			PH_PAD: begin
				phase_n = PH_ID;
			end
			default: begin
				phase_n = PH_SKIP;
			end
		endcase

		// buffer end: a record still open is cut short
		rep_end = !cfg.match_enable || (rid_n == cfg.match_id);
		if (item.in_last) begin
			if ((phase_n == PH_PAYLOAD || phase_n == PH_STRING) && rep_end) begin
				l_v = 1'b1;
				if (cfg.match_enable) found_n = 1'b1;
			end
			nf_v = cfg.match_enable && !found_n;
			phase_n = PH_ID;
			rid_n = '0;
			rtype_n = '0;
			pcnt_n = '0;
			vs_n = '0;
			found_n = 1'b0;
		end
	end

	// pack up to two results in order: main, cut-short invalid, not found
	// an open record at the buffer end never started on this byte, so its id is rid_q
	always_comb begin
		pair = '0;
		pair.cnt = 2'(m_v) + 2'(l_v) + 2'(nf_v);
		if (m_v) begin
			pair.r0.out_id = rid_q;
			pair.r0.out_kind = m_kind;
			pair.r0.out_value = m_val;
		end else if (l_v) begin
			pair.r0.out_id = rid_q;
			pair.r0.out_kind = tlvp_pkg::KIND_INVALID;
		end else begin
			pair.r0.out_id = cfg.match_id;
			pair.r0.out_kind = tlvp_pkg::KIND_NOT_FOUND;
		end
		if (m_v && l_v) begin
			pair.r1.out_id = rid_q;
			pair.r1.out_kind = tlvp_pkg::KIND_INVALID;
		end else begin
			pair.r1.out_id = cfg.match_id;
			pair.r1.out_kind = tlvp_pkg::KIND_NOT_FOUND;
		end
		pair.r0.out_last = (pair.cnt == 2'd1);
		pair.r1.out_last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_ID;
			rid_q <= '0;
			rtype_q <= '0;
			pcnt_q <= '0;
			vs_q <= '0;
			found_q <= 1'b0;
		end else if (advance) begin
			phase_q <= phase_n;
			rid_q <= rid_n;
			rtype_q <= rtype_n;
			pcnt_q <= pcnt_n;
			vs_q <= vs_n;
			found_q <= found_n;
		end
	end

endmodule

/* src/tlvp_outbuf.sv */
// ----------------------------------------------------------------------------
// tlvp_outbuf
// Result register pair: holds the results of one byte and hands them out
// one transaction at a time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tlvp_outbuf (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  tlvp_pkg::result_pair_t pair,
	input  logic                   out_ready,
	output logic                   out_valid,
	output tlvp_pkg::out_item_t    out_data,
	output tlvp_pkg::buf_status_t  status
);

	tlvp_pkg::out_item_t r0_q, r1_q;
	logic [1:0]          cnt_q;
	logic                sel_q;
	logic                fire;

	assign out_valid = (cnt_q != 2'd0);
	assign out_data = sel_q ? r1_q : r0_q;
	assign fire = out_valid && out_ready;

	// free when empty or the last held result leaves this cycle
	assign status.cnt = cnt_q;
	assign status.can_load = (cnt_q == 2'd0) || (cnt_q == 2'd1 && out_ready);

	always_ff @(posedge clk) begin
		if (load) begin
			r0_q <= pair.r0;
			r1_q <= pair.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			sel_q <= 1'b0;
		end else if (load) begin
			cnt_q <= pair.cnt;
			sel_q <= 1'b0;
		end else if (fire) begin
			cnt_q <= cnt_q - 2'd1;
			sel_q <= 1'b1;
		end
	end

endmodule

/* test/tlv_value_record_parser_core_tb.sv */
// ----------------------------------------------------------------------------
// tlv_value_record_parser_core_tb
// Self-checking bench for the value record parser. A short table of
// hand-written buffers comes first: a top value, both numeric record
// types, a string cut short, an unknown type, a missing payload and a lone
// id. Randomly built buffers follow, under several id filter settings. An
// in-bench parser model predicts every result, and each result transaction
// is compared field by field in order. Both channels idle at random. One
// long output stall backs the block up. The sender drains at times.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tlv_value_record_parser_core_tb;

	localparam int CYCLE_LIMIT   = 800000;
	localparam int SETTLE_CYCLES = 16;
	localparam int PHASE_BYTES   = 260;
	localparam int NUM_PHASES    = 6;
	localparam int HOLD_CYCLES   = 400;

	// record type bytes and payload byte positions
	localparam logic [7:0] TYPE_NUM4         = 8'd1;
	localparam logic [7:0] TYPE_NUM10        = 8'd3;
	localparam logic [7:0] TYPE_STR          = 8'd4;
	localparam logic [3:0] NUM4_LAST_IDX     = 4'd3;
	localparam logic [3:0] NUM10_FIRST_IDX   = 4'd5;
	localparam logic [3:0] NUM10_LAST_IDX    = 4'd8;
	localparam logic [3:0] STR_SKIP_LAST_IDX = 4'd4;

	typedef enum logic [2:0] {
		AWAIT_ID, AWAIT_TYPE, IN_PAYLOAD, IN_STRING, AWAIT_PAD, SKIP_REST
	} parse_phase_e;

	typedef enum logic [1:0] {REC_NUM4, REC_NUM10, REC_STR} rec_kind_e;

	typedef struct packed {
		logic [7:0]          data_b;
		logic                last;
		logic                typed;
		tlvp_pkg::out_item_t res;
	} stim_row_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	tlvp_pkg::in_item_t  in_data;
	logic                out_valid;
	logic                out_ready;
	tlvp_pkg::out_item_t out_data;
	logic                cfg_valid;
	logic                cfg_ready;
	logic                cfg_index;
	logic [7:0]          cfg_data;

	// parser model state and its copy of the registers
	parse_phase_e ph;
	rec_kind_e    rec_kind;
	logic [7:0]   rec_id;
	logic [3:0]   pay_cnt;
	logic [31:0]  val_acc;
	logic         found;
	logic         cfg_match_en;
	logic [7:0]   cfg_match_id;

	tlvp_pkg::out_item_t step_q[$];
	tlvp_pkg::out_item_t pending_results[$];
	logic [7:0]          frame_bytes[$];
	stim_row_t           script[$];

	int  err_count   = 0;
	int  cycle_count = 0;
	int  sent_bytes;
	int  hold_left   = 0;
	bit  tight;

	tlv_value_record_parser_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 19);
		if (r < 14)
			return $urandom_range(1, 3);
		else if (r < 19)
			return $urandom_range(4, 10);
		return $urandom_range(20, 50);
	endfunction

	function automatic logic [7:0] rnd_byte();
		int r;
		r = $urandom_range(0, 7);
		if (r == 0)
			return 8'h00;
		else if (r == 1)
			return 8'hFF;
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic void note(logic [7:0] id, logic [2:0] kind, logic [31:0] v);
		step_q.push_back('{out_id: id, out_kind: kind, out_value: v, out_last: 1'b0});
	endfunction

	function automatic void close_record(bit rep, bit invalid);
		if (rep && cfg_match_en) begin
			found = 1'b1;
			ph = SKIP_REST;
		end else begin
			ph = invalid ? SKIP_REST : AWAIT_PAD;
		end
	endfunction

	// advance the model by one byte; the results land in step_q
	task automatic parse_step(input logic [7:0] b, input logic last);
		bit rep;
		step_q.delete();
		rep = !cfg_match_en || (rec_id == cfg_match_id);
		case (ph)
			AWAIT_ID: begin
				rec_id = b;
				pay_cnt = '0;
				val_acc = '0;
				ph = AWAIT_TYPE;
			end
			AWAIT_TYPE: begin
				if (b == TYPE_NUM4 || b == TYPE_NUM10 || b == TYPE_STR) begin
					if (b == TYPE_NUM4)
						rec_kind = REC_NUM4;
					else if (b == TYPE_NUM10)
						rec_kind = REC_NUM10;
					else
						rec_kind = REC_STR;
					pay_cnt = '0;
					ph = IN_PAYLOAD;
				end else begin
					if (rep)
						note(rec_id, tlvp_pkg::KIND_INVALID, '0);
					close_record(rep, 1'b1);
				end
			end
			IN_PAYLOAD: begin
				if (rec_kind == REC_STR) begin
					if (pay_cnt >= STR_SKIP_LAST_IDX)
						ph = IN_STRING;
					else
						pay_cnt++;
				end else begin
					if (rec_kind == REC_NUM4 || pay_cnt >= NUM10_FIRST_IDX)
						val_acc = {val_acc[23:0], b};
					if (pay_cnt >= ((rec_kind == REC_NUM4) ? NUM4_LAST_IDX : NUM10_LAST_IDX)) begin
						if (rep)
							note(rec_id, tlvp_pkg::KIND_NUMERIC, val_acc);
						close_record(rep, 1'b0);
					end else begin
						pay_cnt++;
					end
				end
			end
			IN_STRING: begin
				if (b == 8'h00) begin
					if (rep)
						note(rec_id, tlvp_pkg::KIND_STR_END, '0);
					close_record(rep, 1'b0);
				end else if (rep) begin
					note(rec_id, tlvp_pkg::KIND_CHAR, {24'h0, b});
				end
			end
			AWAIT_PAD: ph = AWAIT_ID;
			default: ph = SKIP_REST;
		endcase

		if (last) begin
			// record open at the buffer end counts as invalid
			if (ph == IN_PAYLOAD || ph == IN_STRING) begin
				rep = !cfg_match_en || (rec_id == cfg_match_id);
				if (rep) begin
					note(rec_id, tlvp_pkg::KIND_INVALID, '0);
					if (cfg_match_en)
						found = 1'b1;
				end
			end
			if (cfg_match_en && !found)
				note(cfg_match_id, tlvp_pkg::KIND_NOT_FOUND, '0);
			ph = AWAIT_ID;
			rec_id = '0;
			rec_kind = REC_NUM4;
			pay_cnt = '0;
			val_acc = '0;
			found = 1'b0;
		end
		if (step_q.size() > 0)
			step_q[$].out_last = 1'b1;
	endtask

	// called at a clock edge; returns at an edge, in_valid still high unless dropped for an idle gap
	task automatic send_byte(input logic [7:0] b, input logic last, input logic use_typed,
			input tlvp_pkg::out_item_t typed_res);
		in_valid <= 1'b1;
		in_data <= '{in_byte: b, in_last: last};
		do @(negedge clk); while (!in_ready);
		sent_bytes++;
		parse_step(b, last);
		if (use_typed)
			pending_results.push_back(typed_res);
		else
			foreach (step_q[i]) pending_results.push_back(step_q[i]);
		@(posedge clk);
		if (!tight && $urandom_range(0, 2) == 0) begin
			in_valid <= 1'b0;
			repeat (pick_gap()) @(posedge clk);
		end
	endtask

	task automatic write_reg(input logic idx, input logic [7:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(negedge clk); while (!cfg_ready);
		if (idx == tlvp_pkg::CFG_MATCH_ENABLE)
			cfg_match_en = value[0];
		else
			cfg_match_id = value;
		@(posedge clk);
	endtask

	task automatic wait_drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic append_record(input logic [7:0] rid);
		int sel;
		int n_chars;
		logic [7:0] ty;
		sel = $urandom_range(0, 9);
		if (sel < 3)
			ty = TYPE_NUM4;
		else if (sel < 6)
			ty = TYPE_NUM10;
		else if (sel < 9)
			ty = TYPE_STR;
		else
			ty = rnd_byte();
		frame_bytes.push_back(rid);
		frame_bytes.push_back(ty);
		if (ty == TYPE_NUM4) begin
			repeat (4) frame_bytes.push_back(rnd_byte());
		end else if (ty == TYPE_NUM10) begin
			repeat (9) frame_bytes.push_back(rnd_byte());
		end else if (ty == TYPE_STR) begin
			repeat (5) frame_bytes.push_back(rnd_byte());
			n_chars = $urandom_range(0, 6);
			repeat (n_chars) frame_bytes.push_back(8'($urandom_range(1, 255)));
			frame_bytes.push_back(8'h00);
		end
		// pad byte, now and then left out
		if ((ty == TYPE_NUM4 || ty == TYPE_NUM10 || ty == TYPE_STR) &&
				$urandom_range(0, 7) != 0)
			frame_bytes.push_back(rnd_byte());
	endtask

	task automatic send_buffer();
		int n_rec;
		int r;
		frame_bytes.delete();
		n_rec = $urandom_range(1, 4);
		repeat (n_rec) begin
			if (cfg_match_en && $urandom_range(0, 2) == 0)
				append_record(cfg_match_id);
			else
				append_record(rnd_byte());
		end
		r = $urandom_range(0, 9);
		if (r < 2 && frame_bytes.size() > 1)
			frame_bytes = frame_bytes[0:$urandom_range(0, frame_bytes.size() - 2)];
		else if (r == 2)
			frame_bytes.push_back(rnd_byte());
		foreach (frame_bytes[i])
			send_byte(frame_bytes[i], i == frame_bytes.size() - 1, 1'b0, '0);
	endtask

	function automatic void push_plain(logic [7:0] b, logic last);
		script.push_back('{data_b: b, last: last, typed: 1'b0, res: '0});
	endfunction

	function automatic void push_typed(logic [7:0] b, logic last, logic [7:0] id,
			logic [2:0] kind, logic [31:0] v);
		script.push_back('{data_b: b, last: last, typed: 1'b1,
			res: '{out_id: id, out_kind: kind, out_value: v, out_last: 1'b1}});
	endfunction

	task automatic cmp_field(input string what, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			err_count++;
			$display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
		end
	endtask

	// output side: ready pattern, with the long hold counted here
	initial begin : out_pacing
		int stall_left;
		int mode_left;
		bit eager;
		stall_left = 0;
		mode_left = 0;
		eager = 1'b0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (mode_left == 0) begin
				eager = ($urandom_range(0, 3) == 0);
				mode_left = $urandom_range(20, 200);
			end else begin
				mode_left--;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (!eager && $urandom_range(0, 3) == 0)
					stall_left = pick_gap();
			end
		end
	end

	// values are stable at the falling edge and hold through the next rising edge
	always @(negedge clk) begin : result_check
		tlvp_pkg::out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				err_count++;
				$display("%0t: unexpected result: expected none, actual id %h kind %0d value %h last %b",
					$time, out_data.out_id, out_data.out_kind, out_data.out_value,
					out_data.out_last);
			end else begin
				want = pending_results.pop_front();
				cmp_field("out_id", 32'(want.out_id), 32'(out_data.out_id));
				cmp_field("out_kind", 32'(want.out_kind), 32'(out_data.out_kind));
				cmp_field("out_value", want.out_value, out_data.out_value);
				cmp_field("out_last", 32'(want.out_last), 32'(out_data.out_last));
			end
		end
	end

	initial begin : stimulus
		logic       set_en [NUM_PHASES];
		logic [7:0] set_id [NUM_PHASES];
		int         tight_bufs;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = tlvp_pkg::CFG_MATCH_ENABLE;
		cfg_data = '0;
		tight = 1'b0;
		sent_bytes = 0;
		ph = AWAIT_ID;
		rec_kind = REC_NUM4;
		rec_id = '0;
		pay_cnt = '0;
		val_acc = '0;
		found = 1'b0;
		cfg_match_en = 1'b0;
		cfg_match_id = '0;

		// type 1 at the top value, buffer ends without pad
		push_plain(8'hFF, 1'b0);
		push_plain(TYPE_NUM4, 1'b0);
		repeat (3) push_plain(8'hFF, 1'b0);
		push_typed(8'hFF, 1'b1, 8'hFF, tlvp_pkg::KIND_NUMERIC, 32'hFFFF_FFFF);
		// type 3: five skipped bytes, then the value
		push_plain(8'h00, 1'b0);
		push_plain(TYPE_NUM10, 1'b0);
		repeat (5) push_plain(8'h00, 1'b0);
		push_plain(8'h01, 1'b0);
		push_plain(8'h02, 1'b0);
		push_plain(8'h03, 1'b0);
		push_typed(8'h04, 1'b1, 8'h00, tlvp_pkg::KIND_NUMERIC, 32'h0102_0304);
		// string cut short after two characters
		push_plain(8'h7E, 1'b0);
		push_plain(TYPE_STR, 1'b0);
		push_plain(8'h80, 1'b0);
		push_plain(8'h7F, 1'b0);
		push_plain(8'h55, 1'b0);
		push_plain(8'hAA, 1'b0);
		push_plain(8'h01, 1'b0);
		push_plain(8'h41, 1'b0);
		push_plain(8'hFF, 1'b1);
		// unknown type byte
		push_plain(8'h33, 1'b0);
		push_typed(8'h00, 1'b1, 8'h33, tlvp_pkg::KIND_INVALID, 32'h0);
		// header complete, payload missing
		push_plain(8'h44, 1'b0);
		push_typed(TYPE_NUM4, 1'b1, 8'h44, tlvp_pkg::KIND_INVALID, 32'h0);
		// lone id byte is dropped
		push_plain(8'h55, 1'b1);

		set_en = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1};
		set_id = '{8'h00, 8'h00, 8'hFF, 8'($urandom_range(0, 255)), 8'hFF,
			8'($urandom_range(0, 255))};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i])
			send_byte(script[i].data_b, script[i].last, script[i].typed, script[i].res);
		wait_drain();

		for (int p = 0; p < NUM_PHASES; p++) begin
			write_reg(tlvp_pkg::CFG_MATCH_ID, set_id[p]);
			write_reg(tlvp_pkg::CFG_MATCH_ENABLE, {7'($urandom_range(0, 127)), set_en[p]});
			cfg_valid <= 1'b0;
			@(posedge clk);
			tight_bufs = 0;
			if (p == 0) begin
				// long output hold while bytes keep coming
				@(negedge clk);
				hold_left = HOLD_CYCLES;
				@(posedge clk);
				tight_bufs = 6;
			end
			sent_bytes = 0;
			while (sent_bytes < PHASE_BYTES) begin
				if (tight_bufs > 0) begin
					tight = 1'b1;
					tight_bufs--;
				end else begin
					tight = ($urandom_range(0, 3) == 0);
				end
				send_buffer();
				if ($urandom_range(0, 19) == 0)
					wait_drain();
			end
			tight = 1'b0;
			wait_drain();
		end

		if (err_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

/* files.f */
+incdir+src
src/tlvp_pkg.sv
src/tlvp_parse.sv
src/tlvp_outbuf.sv
src/tlv_value_record_parser_core.sv
test/tlv_value_record_parser_core_tb.sv
